// ===== design/mpv_pkg.sv =====
// Shared types, constants and functions for the Merkle proof verifier.
package mpv_pkg;

  localparam int unsigned MAX_LEVELS = 20;
  localparam int unsigned LVL_W = $clog2(MAX_LEVELS + 1);
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef logic [0:7][31:0]  hstate_t;
  typedef logic [0:15][31:0] block_t;

  typedef enum logic [1:0] {
    REQ_DATA = 2'd0,
    REQ_SIBLING = 2'd1,
    REQ_ROOT = 2'd2,
    REQ_UNUSED = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    VERDICT_MATCH = 2'd0,
    VERDICT_MISMATCH = 2'd1,
    VERDICT_SEQ_ERR = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_SIBLING,
    KIND_ROOT,
    KIND_BAD
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DATA,
    PH_SIBLINGS
  } phase_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DATA,
    B_HEX,
    B_PAD80,
    B_PADZ,
    B_LEN,
    B_COMP,
    B_FIN
  } back_state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [19:0] leaf_index;
    logic [63:0] data_word;
    logic [3:0]  data_count;
    logic        data_last;
    logic [63:0] hash_w0;
    logic [63:0] hash_w1;
    logic [63:0] hash_w2;
    logic [63:0] hash_w3;
  } in_item_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [4:0] levels_done;
  } out_item_t;

  // Item as held in the queue, already classified.
  typedef struct packed {
    kind_e        kind;
    logic [19:0]  leaf_index;
    logic [63:0]  data_word;
    logic [3:0]   count;
    logic         last;
    logic [255:0] hash;
  } q_item_t;

  localparam hstate_t IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'd0, v};
    end else begin
      r = 8'h57 + {4'd0, v};
    end
    return r;
  endfunction

endpackage

// ===== design/mpv_sha_core.sv =====
// Iterative SHA-256 compression unit, one round per cycle.
module mpv_sha_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  mpv_pkg::block_t  blk_i,
  input  mpv_pkg::hstate_t chain_i,
  output logic             done_o,
  output mpv_pkg::hstate_t hash_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [5:0]       rnd_q, rnd_d;
  mpv_pkg::hstate_t s_q, s_d;
  mpv_pkg::block_t  win_q, win_d;

  logic [31:0] a, e, t1, t2, s0w, s1w, wnew;

  always_comb begin
    a = s_q[0];
    e = s_q[4];
    t1 = s_q[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
       + ((e & s_q[5]) ^ (~e & s_q[6])) + mpv_pkg::RK[rnd_q] + win_q[0];
    t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
       + ((a & s_q[1]) ^ (a & s_q[2]) ^ (s_q[1] & s_q[2]));
    s0w = {win_q[1][6:0], win_q[1][31:7]} ^ {win_q[1][17:0], win_q[1][31:18]}
        ^ (win_q[1] >> 3);
    s1w = {win_q[14][16:0], win_q[14][31:17]} ^ {win_q[14][18:0], win_q[14][31:19]}
        ^ (win_q[14] >> 10);
    wnew = win_q[0] + s0w + win_q[9] + s1w;

    busy_d = busy_q;
    done_d = 1'b0;
    rnd_d = rnd_q;
    s_d = s_q;
    win_d = win_q;
    if (start_i) begin
      busy_d = 1'b1;
      rnd_d = '0;
      s_d = chain_i;
      win_d = blk_i;
    end else if (busy_q) begin
      s_d = {t1 + t2, s_q[0], s_q[1], s_q[2], s_q[3] + t1, s_q[4], s_q[5], s_q[6]};
      win_d = {win_q[1:15], wnew};
      rnd_d = rnd_q + 6'd1;
      if (rnd_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      rnd_q <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
    win_q <= win_d;
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hash_o[i] = chain_i[i] + s_q[i];
    end
  end

  assign done_o = done_q;

endmodule

// ===== design/mpv_front.sv =====
// Input side: classifies items and holds them in a short queue.
module mpv_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mpv_pkg::in_item_t in_i,
  input  logic              pop_i,
  output logic              q_valid_o,
  output mpv_pkg::q_item_t  q_o
);

  localparam int unsigned PTR_W = $clog2(mpv_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(mpv_pkg::QUEUE_DEPTH + 1);

  mpv_pkg::q_item_t mem_q [mpv_pkg::QUEUE_DEPTH];
  mpv_pkg::q_item_t item;
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  always_comb begin
    unique case (in_i.req_type)
      mpv_pkg::REQ_DATA: item.kind = mpv_pkg::KIND_DATA;
      mpv_pkg::REQ_SIBLING: item.kind = mpv_pkg::KIND_SIBLING;
      mpv_pkg::REQ_ROOT: item.kind = mpv_pkg::KIND_ROOT;
      default: item.kind = mpv_pkg::KIND_BAD;
    endcase
    item.leaf_index = in_i.leaf_index;
    item.data_word = in_i.data_word;
    // Counts above eight are taken as a full word.
    item.count = (in_i.data_count > 4'd8) ? 4'd8 : in_i.data_count;
    item.last = in_i.data_last;
    item.hash = {in_i.hash_w0, in_i.hash_w1, in_i.hash_w2, in_i.hash_w3};
  end

  assign in_ready_o = (cnt_q != CNT_W'(mpv_pkg::QUEUE_DEPTH));
  assign q_valid_o = (cnt_q != '0);
  assign q_o = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop = pop_i && q_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PTR_W'(mpv_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PTR_W'(mpv_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item;
    end
  end

endmodule

// ===== design/mpv_back.sv =====
// Execution side: byte packing, padding, hex expansion, hashing and the verdict.
module mpv_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  mpv_pkg::q_item_t   q_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mpv_pkg::out_item_t out_o
);

  mpv_pkg::back_state_e state_q, state_d, ret_q, ret_d, nxt;
  mpv_pkg::phase_e      phase_q, phase_d;
  mpv_pkg::hstate_t     chain_q, chain_d, core_hash;
  mpv_pkg::block_t      blk_q, blk_d;
  logic [255:0]         digest_q, digest_d;
  logic [5:0]           fill_q, fill_d;
  logic [63:0]          msg_q, msg_d;
  logic [19:0]          pos_q, pos_d;
  logic [mpv_pkg::LVL_W-1:0] lvl_q, lvl_d;
  logic [63:0]          dw_q, dw_d, len_q, len_d;
  logic [3:0]           left_q, left_d;
  logic                 last_q, last_d, sib_q, sib_d;
  logic [511:0]         hx_q, hx_d;
  logic [6:0]           hcnt_q, hcnt_d;
  logic [2:0]           lcnt_q, lcnt_d;
  logic                 run_q, run_d;
  logic                 out_valid_q, out_valid_d;
  mpv_pkg::out_item_t   out_q, out_d;
  logic                 put, core_start, core_done, report;
  logic [7:0]           put_byte;
  logic [1:0]           verdict;
  logic [4:0]           sh;

  mpv_sha_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (core_start),
    .blk_i   (blk_q),
    .chain_i (chain_q),
    .done_o  (core_done),
    .hash_o  (core_hash)
  );

  assign core_start = (state_q == mpv_pkg::B_COMP) && !run_q;
  assign sh = {~fill_q[1:0], 3'b000};

  always_comb begin
    nxt = state_q;
    ret_d = ret_q;
    phase_d = phase_q;
    chain_d = chain_q;
    blk_d = blk_q;
    digest_d = digest_q;
    fill_d = fill_q;
    msg_d = msg_q;
    pos_d = pos_q;
    lvl_d = lvl_q;
    dw_d = dw_q;
    len_d = len_q;
    left_d = left_q;
    last_d = last_q;
    sib_d = sib_q;
    hx_d = hx_q;
    hcnt_d = hcnt_q;
    lcnt_d = lcnt_q;
    run_d = run_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d = out_q;
    pop_o = 1'b0;
    put = 1'b0;
    put_byte = '0;
    report = 1'b0;
    verdict = mpv_pkg::VERDICT_SEQ_ERR;

    unique case (state_q)
      mpv_pkg::B_IDLE: begin
        if (q_valid_i && !out_valid_q) begin
          pop_o = 1'b1;
          unique case (q_i.kind)
            mpv_pkg::KIND_DATA: begin
              if (phase_q == mpv_pkg::PH_SIBLINGS) begin
                report = 1'b1;
              end else begin
                if (phase_q == mpv_pkg::PH_IDLE) begin
                  chain_d = mpv_pkg::IV;
                  fill_d = '0;
                  msg_d = '0;
                  pos_d = q_i.leaf_index;
                  phase_d = mpv_pkg::PH_DATA;
                end
                dw_d = q_i.data_word;
                left_d = q_i.count;
                last_d = q_i.last;
                sib_d = 1'b0;
                nxt = mpv_pkg::B_DATA;
              end
            end
            mpv_pkg::KIND_SIBLING: begin
              if (phase_q != mpv_pkg::PH_SIBLINGS ||
                  lvl_q >= mpv_pkg::LVL_W'(mpv_pkg::MAX_LEVELS)) begin
                report = 1'b1;
              end else begin
                chain_d = mpv_pkg::IV;
                fill_d = '0;
                msg_d = '0;
                // The running digest goes on the left for an even position.
                hx_d = pos_q[0] ? {q_i.hash, digest_q} : {digest_q, q_i.hash};
                hcnt_d = '1;
                sib_d = 1'b1;
                nxt = mpv_pkg::B_HEX;
              end
            end
            mpv_pkg::KIND_ROOT: begin
              report = 1'b1;
              if (phase_q == mpv_pkg::PH_SIBLINGS) begin
                verdict = (q_i.hash == digest_q) ? mpv_pkg::VERDICT_MATCH
                                                 : mpv_pkg::VERDICT_MISMATCH;
              end
            end
            default: report = 1'b1;
          endcase
        end
      end
      mpv_pkg::B_DATA: begin
        if (left_q == '0) begin
          nxt = last_q ? mpv_pkg::B_PAD80 : mpv_pkg::B_IDLE;
        end else begin
          put = 1'b1;
          put_byte = dw_q[63:56];
          dw_d = {dw_q[55:0], 8'h00};
          left_d = left_q - 4'd1;
          msg_d = msg_q + 64'd1;
        end
      end
      mpv_pkg::B_HEX: begin
        put = 1'b1;
        put_byte = mpv_pkg::hex_char(hx_q[511:508]);
        hx_d = {hx_q[507:0], 4'h0};
        hcnt_d = hcnt_q - 7'd1;
        msg_d = msg_q + 64'd1;
        if (hcnt_q == '0) begin
          nxt = mpv_pkg::B_PAD80;
        end
      end
      mpv_pkg::B_PAD80: begin
        put = 1'b1;
        put_byte = 8'h80;
        len_d = {msg_q[60:0], 3'b000};
        lcnt_d = '1;
        nxt = mpv_pkg::B_PADZ;
      end
      mpv_pkg::B_PADZ: begin
        if (fill_q == 6'd56) begin
          nxt = mpv_pkg::B_LEN;
        end else begin
          put = 1'b1;
        end
      end
      mpv_pkg::B_LEN: begin
        put = 1'b1;
        put_byte = len_q[63:56];
        len_d = {len_q[55:0], 8'h00};
        lcnt_d = lcnt_q - 3'd1;
        if (lcnt_q == '0) begin
          nxt = mpv_pkg::B_FIN;
        end
      end
      mpv_pkg::B_COMP: begin
        if (!run_q) begin
          run_d = 1'b1;
        end else if (core_done) begin
          run_d = 1'b0;
          chain_d = core_hash;
          fill_d = '0;
          nxt = ret_q;
        end
      end
      mpv_pkg::B_FIN: begin
        digest_d = chain_q;
        phase_d = mpv_pkg::PH_SIBLINGS;
        if (sib_q) begin
          pos_d = {1'b0, pos_q[19:1]};
          lvl_d = lvl_q + mpv_pkg::LVL_W'(1);
        end
        nxt = mpv_pkg::B_IDLE;
      end
      default: nxt = mpv_pkg::B_IDLE;
    endcase

    state_d = nxt;
    if (put) begin
      blk_d[fill_q[5:2]][sh +: 8] = put_byte;
      fill_d = fill_q + 6'd1;
      // A full block is compressed before the sequence goes on.
      if (fill_q == 6'd63) begin
        ret_d = nxt;
        state_d = mpv_pkg::B_COMP;
      end
    end

    if (report) begin
      out_valid_d = 1'b1;
      out_d.verdict = verdict;
      out_d.levels_done = 5'(lvl_q);
      chain_d = mpv_pkg::IV;
      fill_d = '0;
      msg_d = '0;
      digest_d = '0;
      pos_d = '0;
      lvl_d = '0;
      phase_d = mpv_pkg::PH_IDLE;
      state_d = mpv_pkg::B_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpv_pkg::B_IDLE;
      ret_q <= mpv_pkg::B_IDLE;
      phase_q <= mpv_pkg::PH_IDLE;
      chain_q <= mpv_pkg::IV;
      digest_q <= '0;
      fill_q <= '0;
      msg_q <= '0;
      pos_q <= '0;
      lvl_q <= '0;
      run_q <= 1'b0;
      out_valid_q <= 1'b0;
      sib_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q <= ret_d;
      phase_q <= phase_d;
      chain_q <= chain_d;
      digest_q <= digest_d;
      fill_q <= fill_d;
      msg_q <= msg_d;
      pos_q <= pos_d;
      lvl_q <= lvl_d;
      run_q <= run_d;
      out_valid_q <= out_valid_d;
      sib_q <= sib_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    dw_q <= dw_d;
    len_q <= len_d;
    left_q <= left_d;
    last_q <= last_d;
    hx_q <= hx_d;
    hcnt_q <= hcnt_d;
    lcnt_q <= lcnt_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o = out_q;

endmodule

// ===== design/merkle_proof_verifier.sv =====
// A data item packs its bytes and compresses every 64-byte block that it fills;
// closing the leaf adds padding and length and one or two compressions.
// A sibling item packs 128 hex bytes, adds padding and runs three compressions.
// All hashing runs on the single one-round-per-cycle SHA-256 unit; a root item is not hashed.
// Reset (asynchronous, active low) empties the queue and returns to awaiting data.
// Top level of the Merkle inclusion proof verifier.
module merkle_proof_verifier (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mpv_pkg::in_item_t  in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mpv_pkg::out_item_t out_o
);

  logic             q_valid, pop;
  mpv_pkg::q_item_t q_item;

  mpv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .pop_i      (pop),
    .q_valid_o  (q_valid),
    .q_o        (q_item)
  );

  mpv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_i         (q_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

// ===== design/mpv_checker.sv =====
// Port-level checks for the Merkle proof verifier, bound to the top level.
module mpv_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input mpv_pkg::out_item_t out_o
);

  // A result that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result changed while stalled");

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.verdict != 2'd3)
    else $error("undefined verdict code");

  // A match or mismatch verdict can never count more levels than the proof limit allows.
  a_levels_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.verdict == mpv_pkg::VERDICT_MATCH ||
                    out_o.verdict == mpv_pkg::VERDICT_MISMATCH)
    |-> 32'(out_o.levels_done) <= mpv_pkg::MAX_LEVELS)
    else $error("level count beyond limit");

endmodule

bind merkle_proof_verifier mpv_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

// ===== tb/sv/tb_merkle_proof_verifier.sv =====
// Self-checking testbench for the SHA-256 Merkle inclusion proof verifier.
`timescale 1ns / 100ps

module tb_merkle_proof_verifier;

  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 600;
  localparam int unsigned RANDOM_ITEMS = 1750;

  class proof_scoreboard;
    bit [31:0] chain[8];
    bit [31:0] words[16];
    int unsigned fill;
    longint unsigned msg_len;
    bit [63:0] digest[4];
    bit [19:0] path_bits;
    int unsigned levels;
    mpv_pkg::phase_e stage;
    mpv_pkg::out_item_t verdicts_due[$];
    int unsigned errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      foreach (chain[i]) chain[i] = mpv_pkg::IV[i];
      foreach (words[i]) words[i] = '0;
      fill = 0;
      msg_len = 0;
      foreach (digest[i]) digest[i] = '0;
      path_bits = '0;
      levels = 0;
      stage = mpv_pkg::PH_IDLE;
    endfunction

    function bit [31:0] rotr(bit [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      bit [31:0] w[64];
      bit [31:0] s[8];
      bit [31:0] t1;
      bit [31:0] t2;
      for (int i = 0; i < 16; i++) w[i] = words[i];
      for (int i = 16; i < 64; i++) begin
        w[i] = w[i-16] + w[i-7]
             + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
             + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
      end
      for (int i = 0; i < 8; i++) s[i] = chain[i];
      for (int i = 0; i < 64; i++) begin
        t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25))
           + ((s[4] & s[5]) ^ (~s[4] & s[6])) + mpv_pkg::RK[i] + w[i];
        t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22))
           + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
        s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
        s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += s[i];
    endfunction

    function void put_byte(bit [7:0] b);
      int unsigned sh;
      sh = 24 - 8 * (fill % 4);
      words[fill / 4][sh +: 8] = b;
      fill++;
      if (fill >= 64) begin
        compress();
        fill = 0;
      end
    endfunction

    function void start_hash();
      foreach (chain[i]) chain[i] = mpv_pkg::IV[i];
      fill = 0;
      msg_len = 0;
    endfunction

    function void absorb(bit [7:0] b);
      put_byte(b);
      msg_len++;
    endfunction

    function void finish_hash();
      bit [63:0] bits;
      bits = msg_len << 3;
      put_byte(8'h80);
      while (fill != 56) put_byte(8'h00);
      for (int i = 7; i >= 0; i--) put_byte(bits[8*i +: 8]);
      for (int i = 0; i < 4; i++) digest[i] = {chain[2*i], chain[2*i+1]};
    endfunction

    function void absorb_hex(bit [255:0] d);
      bit [3:0] v;
      for (int n = 0; n < 64; n++) begin
        v = d[255 - 4*n -: 4];
        absorb(v < 10 ? 8'h30 + v : 8'h57 + v);
      end
    endfunction

    function bit [255:0] current();
      return {digest[0], digest[1], digest[2], digest[3]};
    endfunction

    function void post_verdict(mpv_pkg::verdict_e v);
      mpv_pkg::out_item_t o;
      o.verdict = v;
      o.levels_done = levels[4:0];
      verdicts_due.insert(verdicts_due.size(), o);
      clear();
    endfunction

    // Called for every accepted input item.
    function void note_input(mpv_pkg::in_item_t it);
      bit [255:0] sib;
      bit [255:0] cur;
      int unsigned cnt;
      sib = {it.hash_w0, it.hash_w1, it.hash_w2, it.hash_w3};
      case (mpv_pkg::req_e'(it.req_type))
        mpv_pkg::REQ_DATA: begin
          if (stage == mpv_pkg::PH_SIBLINGS) begin
            post_verdict(mpv_pkg::VERDICT_SEQ_ERR);
          end else begin
            if (stage == mpv_pkg::PH_IDLE) begin
              start_hash();
              path_bits = it.leaf_index;
              stage = mpv_pkg::PH_DATA;
            end
            cnt = (it.data_count > 8) ? 8 : it.data_count;
            for (int i = 0; i < cnt; i++) absorb(it.data_word[63 - 8*i -: 8]);
            if (it.data_last) begin
              finish_hash();
              stage = mpv_pkg::PH_SIBLINGS;
            end
          end
        end
        mpv_pkg::REQ_SIBLING: begin
          if (stage != mpv_pkg::PH_SIBLINGS || levels >= mpv_pkg::MAX_LEVELS) begin
            post_verdict(mpv_pkg::VERDICT_SEQ_ERR);
          end else begin
            cur = current();
            start_hash();
            if (!path_bits[0]) begin
              absorb_hex(cur);
              absorb_hex(sib);
            end else begin
              absorb_hex(sib);
              absorb_hex(cur);
            end
            finish_hash();
            path_bits = path_bits >> 1;
            levels++;
          end
        end
        mpv_pkg::REQ_ROOT: begin
          if (stage == mpv_pkg::PH_SIBLINGS) begin
            post_verdict(sib == current() ? mpv_pkg::VERDICT_MATCH
                                          : mpv_pkg::VERDICT_MISMATCH);
          end else begin
            post_verdict(mpv_pkg::VERDICT_SEQ_ERR);
          end
        end
        default: post_verdict(mpv_pkg::VERDICT_SEQ_ERR);
      endcase
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_verdict(mpv_pkg::out_item_t got);
      mpv_pkg::out_item_t want;
      if (verdicts_due.size() == 0) begin
        report($sformatf("unexpected verdict %0d levels %0d", got.verdict, got.levels_done));
      end else begin
        want = verdicts_due.pop_front();
        if (got.verdict !== want.verdict)
          report($sformatf("verdict %0d, expected %0d", got.verdict, want.verdict));
        if (got.levels_done !== want.levels_done)
          report($sformatf("levels_done %0d, expected %0d", got.levels_done,
                           want.levels_done));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  mpv_pkg::in_item_t in_i;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  mpv_pkg::out_item_t out_o;

  proof_scoreboard sb;
  int unsigned accepted;
  int unsigned items_sent;
  int unsigned idle_cycles;
  int unsigned ready_hold = 0;
  bit no_gaps;

  merkle_proof_verifier u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_i(in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o(out_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit [255:0] rand256();
    return {rand64(), rand64(), rand64(), rand64()};
  endfunction

  // Receiver alternates between runs of ready and stalls of random length.
  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      out_ready_i = !out_ready_i;
      ready_hold = out_ready_i ? $urandom_range(20, 0) : (no_gaps ? 0 : gap_len());
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_input(in_i);
        accepted++;
      end
      if (out_valid_o && out_ready_i) sb.check_verdict(out_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  task automatic send(mpv_pkg::req_e req, bit [19:0] idx, bit [63:0] word, bit [3:0] cnt,
                      bit last, bit [255:0] h);
    mpv_pkg::in_item_t it;
    int unsigned seen;
    it.req_type = req;
    it.leaf_index = idx;
    it.data_word = word;
    it.data_count = cnt;
    it.data_last = last;
    {it.hash_w0, it.hash_w1, it.hash_w2, it.hash_w3} = h;
    repeat (no_gaps ? 0 : gap_len()) @(negedge clk_i);
    in_i = it;
    in_valid_i = 1'b1;
    seen = accepted;
    do @(negedge clk_i); while (accepted == seen);
    in_valid_i = 1'b0;
    items_sent++;
  endtask

  // Streams a shard of nbytes bytes; an empty shard is one item of count zero.
  task automatic send_shard(int unsigned nbytes, bit [19:0] idx);
    int unsigned left;
    int unsigned c;
    bit [3:0] cnt;
    left = nbytes;
    if (nbytes == 0) send(mpv_pkg::REQ_DATA, idx, rand64(), 4'd0, 1'b1, rand256());
    while (left > 0) begin
      if ($urandom_range(19) == 0)
        send(mpv_pkg::REQ_DATA, idx, rand64(), 4'd0, 1'b0, rand256());
      c = $urandom_range(8, 1);
      if (c > left) c = left;
      cnt = 4'(c);
      if (c == 8 && $urandom_range(3) == 0) cnt = 4'($urandom_range(15, 9));
      left -= c;
      send(mpv_pkg::REQ_DATA, idx, rand64(), cnt, left == 0, rand256());
    end
  endtask

  task automatic send_root(bit good);
    bit [255:0] h;
    h = sb.current();
    if (!good) begin
      if ($urandom_range(1)) h = rand256();
      else h[$urandom_range(255)] ^= 1'b1;
    end
    send(mpv_pkg::REQ_ROOT, 20'(rand64()), rand64(), 4'($urandom), 1'($urandom), h);
  endtask

  task automatic run_proof(int unsigned nbytes, int unsigned nsib, bit good,
                           bit [19:0] idx);
    send_shard(nbytes, idx);
    for (int unsigned i = 0; i < nsib; i++)
      send(mpv_pkg::REQ_SIBLING, 20'(rand64()), rand64(), 4'($urandom), 1'($urandom),
           rand256());
    if (nsib <= mpv_pkg::MAX_LEVELS) send_root(good);
  endtask

  initial begin
    int unsigned r;
    int unsigned nbytes;
    int unsigned nsib;
    sb = new();
    accepted = 0;
    items_sent = 0;
    idle_cycles = 0;
    no_gaps = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty shard, extreme words and counts, and each ordering error.
    run_proof(0, 0, 1'b1, 20'h00000);
    send(mpv_pkg::REQ_DATA, 20'hfffff, 64'hffff_ffff_ffff_ffff, 4'd8, 1'b0, '1);
    send(mpv_pkg::REQ_DATA, 20'h00000, 64'h0, 4'd15, 1'b1, '0);
    send(mpv_pkg::REQ_SIBLING, '0, '0, '0, 1'b0, '1);
    send(mpv_pkg::REQ_SIBLING, '1, '1, '1, 1'b1, '0);
    send_root(1'b1);
    run_proof(3, 1, 1'b0, 20'h55555);
    send(mpv_pkg::REQ_SIBLING, '0, '0, 4'd1, 1'b0, rand256());
    send(mpv_pkg::REQ_ROOT, '0, '0, 4'd1, 1'b0, rand256());
    send(mpv_pkg::REQ_UNUSED, '0, '0, 4'd1, 1'b0, rand256());
    send(mpv_pkg::REQ_DATA, 20'haaaaa, rand64(), 4'd4, 1'b0, rand256());
    send(mpv_pkg::REQ_ROOT, '0, '0, 4'd1, 1'b0, rand256());
    send(mpv_pkg::REQ_DATA, 20'h1, rand64(), 4'd2, 1'b1, rand256());
    send(mpv_pkg::REQ_DATA, 20'h1, rand64(), 4'd2, 1'b1, rand256());
    send(mpv_pkg::REQ_DATA, 20'h2, rand64(), 4'd1, 1'b1, rand256());
    send(mpv_pkg::REQ_UNUSED, '1, '1, '1, 1'b1, '1);
    run_proof(5, mpv_pkg::MAX_LEVELS + 1, 1'b1, 20'hfffff);
    run_proof(2, mpv_pkg::MAX_LEVELS, 1'b1, 20'h0f0f0);

    while (items_sent < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      no_gaps = ($urandom_range(5) == 0);
      if (r < 88) begin
        nbytes = ($urandom_range(4) == 0) ? $urandom_range(300) : $urandom_range(70);
        r = $urandom_range(99);
        if (r < 85) nsib = $urandom_range(5);
        else if (r < 95) nsib = $urandom_range(mpv_pkg::MAX_LEVELS, 6);
        else nsib = mpv_pkg::MAX_LEVELS + 1;
        run_proof(nbytes, nsib, $urandom_range(3) != 0, 20'($urandom));
      end else begin
        send(mpv_pkg::req_e'($urandom_range(3)), 20'($urandom), rand64(), 4'($urandom),
             1'($urandom), rand256());
      end
    end
    no_gaps = 1'b0;

    while (sb.verdicts_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== merkle_proof_verifier.f =====
design/mpv_pkg.sv
design/mpv_sha_core.sv
design/mpv_front.sv
design/mpv_back.sv
design/merkle_proof_verifier.sv
design/mpv_checker.sv
tb/sv/tb_merkle_proof_verifier.sv
